/* rtl/fit_block_allocator_top_macros.svh */
// Assertion macros shared by the allocator RTL.
// Expects clk and arst_n in the scope of each use; no other dependencies.
`ifndef FIT_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define FIT_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FBA_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define FBA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define FBA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define FBA_ASSERT_ALWAYS(lbl, cond, msg)
`define FBA_ASSERT_SAME(lbl, ante, cons, msg)
`define FBA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/fba_pkg.sv */
`timescale 1ns / 1ps
// Package of the fit block allocator: field widths, register indexes, mode codes
// and the command/status structs between controller and datapath. No dependencies.
package fba_pkg;

	localparam int NUM_BLOCKS_DEF = 8;
	localparam int SIZE_BITS_DEF  = 16;

	localparam int INDEX_W    = 3;
	localparam int AMOUNT_W   = 16;
	localparam int MODE_W     = 2;
	localparam int BIU_W      = 4;
	localparam int CFG_DATA_W = 4;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE      = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = 1'd1;

	localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
	localparam logic [MODE_W-1:0] MODE_NEXT  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BEST  = 2'd2;

	localparam logic [MODE_W-1:0] FIT_MODE_RESET = MODE_FIRST;
	localparam logic [BIU_W-1:0]  BIU_RESET      = 4'd8;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_ALLOC = 1'b1;

	typedef struct packed {
		logic capture;
		logic issue;
		logic finish;
	} ctl_cmd_t;

	typedef struct packed {
		logic is_load;
		logic count_zero;
		logic last_issue;
	} dp_stat_t;

endpackage

/* rtl/fit_block_allocator_top.sv */
`timescale 1ns / 1ps
// Top level of the fit block allocator: joins sequencer and datapath.
// Depends on fba_pkg, fba_ctrl and fba_datapath.
//
// Usage:
//   Command channel: drive req_type, block_index and amount with start high;
//   the beat is taken at a rising edge where start is high and busy is low.
//   A load (req_type 0) writes one block's free size; an allocate (req_type 1)
//   searches blocks 0..min(blocks_in_use, NUM_BLOCKS)-1 by first, next or best
//   fit and takes the amount from the chosen block.
//   Result channel: every command beat yields exactly one result beat,
//   marked by done for one cycle with granted, chosen_block and block_left.
//   The receiver cannot stall; capture the result in the cycle done is high.
//   Config port: cfg_we with cfg_index (0 fit_mode, 1 blocks_in_use) and
//   cfg_data writes a register at once; write only while busy is low.
//   Timing: a load, or an allocate with no blocks in use, goes from capture
//   through the decide and update states to done; an allocate with blocks
//   in use also scans them, one table read per cycle on the single scan
//   port, then drains the read stage before the update. A new command is
//   taken in the cycle done is high.
//   Reset: all free sizes read zero, next fit pointer zero, first fit,
//   eight blocks in use; no clearing pass is needed.
module fit_block_allocator_top
	import fba_pkg::*;
#(
	parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
	parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  start,
	output logic                  busy,
	input  logic                  req_type,
	input  logic [INDEX_W-1:0]    block_index,
	input  logic [AMOUNT_W-1:0]   amount,
	output logic                  done,
	output logic                  granted,
	output logic [INDEX_W-1:0]    chosen_block,
	output logic [AMOUNT_W-1:0]   block_left
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	// sequencer: one item at a time, advance the scan one block a cycle
	fba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.stat   (stat)
	);

	// datapath: holds the table, config and the registered result beat
	fba_datapath #(
		.NUM_BLOCKS (NUM_BLOCKS),
		.SIZE_BITS  (SIZE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.req_type     (req_type),
		.block_index  (block_index),
		.amount       (amount),
		.granted      (granted),
		.chosen_block (chosen_block),
		.block_left   (block_left)
	);

endmodule

/* rtl/fba_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer of the fit block allocator: capture, scan, update, result strobe.
// Depends on fba_pkg and fit_block_allocator_top_macros.svh.
`include "fit_block_allocator_top_macros.svh"

module fba_ctrl
	import fba_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	output logic     done,
	output ctl_cmd_t cmd,
	input  dp_stat_t stat
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_SCAN,
		ST_DRAIN,
		ST_UPDATE
	} state_t;

	state_t state_q;
	logic   done_q;

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign cmd.capture = (state_q == ST_IDLE) && start;
	assign cmd.issue   = (state_q == ST_SCAN);
	assign cmd.finish  = (state_q == ST_UPDATE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (stat.is_load || stat.count_zero) begin
						state_q <= ST_UPDATE;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (stat.last_issue) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`FBA_ASSERT_NEXT(a_done_single, done, !done, "result strobe held longer than one cycle")
	`FBA_ASSERT_SAME(a_fall_done, $fell(busy), done, "busy dropped without a result strobe")
	`FBA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")

endmodule

/* rtl/fba_datapath.sv */
`timescale 1ns / 1ps
// Datapath of the fit block allocator: config registers, free size table,
// scan address, fit compare and result registers.
// Depends on fba_pkg and fit_block_allocator_top_macros.svh.
`include "fit_block_allocator_top_macros.svh"

module fba_datapath
	import fba_pkg::*;
#(
	parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
	parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctl_cmd_t              cmd,
	output dp_stat_t              stat,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  req_type,
	input  logic [INDEX_W-1:0]    block_index,
	input  logic [AMOUNT_W-1:0]   amount,
	output logic                  granted,
	output logic [INDEX_W-1:0]    chosen_block,
	output logic [AMOUNT_W-1:0]   block_left
);

	localparam int IDX_W = $clog2(NUM_BLOCKS);
	localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

	// configuration
	logic [MODE_W-1:0] fit_mode_q;
	logic [BIU_W-1:0]  biu_q;

	// captured request
	logic                 kind_q;
	logic [INDEX_W-1:0]   idx_in_q;
	logic [SIZE_BITS-1:0] amt_q;
	logic [CNT_W-1:0]     count_q;

	// scan state
	logic [IDX_W-1:0]     pos_q;
	logic [CNT_W-1:0]     step_q;
	logic [IDX_W-1:0]     nf_ptr_q;
	logic                 found_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [SIZE_BITS-1:0] best_size_q;

	// free size table; entries never written read as zero through vld_q
	logic [SIZE_BITS-1:0] mem [NUM_BLOCKS];
	logic [NUM_BLOCKS-1:0] vld_q;

	// read stage
	logic [SIZE_BITS-1:0] rd_data_s1;
	logic                 rd_vld_s1;
	logic [IDX_W-1:0]     rd_pos_s1;
	logic                 rd_pend_s1;

	// result registers
	logic                 granted_q;
	logic [INDEX_W-1:0]   chosen_q;
	logic [AMOUNT_W-1:0]  left_q;

	logic [CNT_W-1:0]     count_w;
	logic [IDX_W-1:0]     start_pos;
	logic [CNT_W-1:0]     pos_inc;
	logic [IDX_W-1:0]     pos_next;
	logic [SIZE_BITS-1:0] rd_size;
	logic                 hit;
	logic                 take;
	logic                 load_ok;
	logic [IDX_W-1:0]     load_addr;
	logic [SIZE_BITS-1:0] left_w;

	always_comb begin
		if (32'(biu_q) > NUM_BLOCKS) begin
			count_w = CNT_W'(NUM_BLOCKS);
		end else begin
			count_w = CNT_W'(biu_q);
		end
	end

	// next fit resumes at the kept pointer unless it lies outside the search range
	assign start_pos = ((fit_mode_q == MODE_NEXT) && (CNT_W'(nf_ptr_q) < count_w)) ?
		nf_ptr_q : '0;
	assign pos_inc   = CNT_W'(pos_q) + CNT_W'(1);
	assign pos_next  = (pos_inc >= count_q) ? '0 : IDX_W'(pos_inc);

	assign rd_size = rd_vld_s1 ? rd_data_s1 : '0;
	assign hit     = (rd_size >= amt_q);
	// best fit replaces only on strictly smaller, so ties keep the lower index
	assign take    = hit && (!found_q || ((fit_mode_q == MODE_BEST) && (rd_size < best_size_q)));

	assign load_ok   = (32'(idx_in_q) < NUM_BLOCKS);
	assign load_addr = IDX_W'(idx_in_q);
	assign left_w    = best_size_q - amt_q;

	assign stat.is_load    = (kind_q == REQ_LOAD);
	assign stat.count_zero = (count_q == '0);
	assign stat.last_issue = ((step_q + CNT_W'(1)) == count_q);

	assign granted      = granted_q;
	assign chosen_block = chosen_q;
	assign block_left   = left_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q <= FIT_MODE_RESET;
			biu_q      <= BIU_RESET;
			kind_q     <= REQ_LOAD;
			count_q    <= '0;
			pos_q      <= '0;
			step_q     <= '0;
			nf_ptr_q   <= '0;
			found_q    <= 1'b0;
			vld_q      <= '0;
			rd_pend_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FIT_MODE:      fit_mode_q <= cfg_data[MODE_W-1:0];
					REG_BLOCKS_IN_USE: biu_q      <= cfg_data[BIU_W-1:0];
					default: ;
				endcase
			end
			rd_pend_s1 <= cmd.issue;
			if (cmd.capture) begin
				kind_q  <= req_type;
				count_q <= count_w;
				pos_q   <= start_pos;
				step_q  <= '0;
				found_q <= 1'b0;
			end
			if (cmd.issue) begin
				pos_q  <= pos_next;
				step_q <= step_q + CNT_W'(1);
			end
			if (rd_pend_s1 && take) begin
				found_q <= 1'b1;
			end
			if (cmd.finish) begin
				if (kind_q == REQ_LOAD) begin
					if (load_ok) begin
						vld_q[load_addr] <= 1'b1;
					end
				end else if (found_q && (fit_mode_q == MODE_NEXT)) begin
					nf_ptr_q <= best_idx_q;
				end
			end
		end
	end

	// payload: request, compare winner, read stage and result
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			idx_in_q <= block_index;
			amt_q    <= SIZE_BITS'(amount);
		end
		if (rd_pend_s1 && take) begin
			best_idx_q  <= rd_pos_s1;
			best_size_q <= rd_size;
		end
		rd_vld_s1 <= vld_q[pos_q];
		rd_pos_s1 <= pos_q;
		if (cmd.finish) begin
			if (kind_q == REQ_LOAD) begin
				granted_q <= load_ok;
				chosen_q  <= load_ok ? idx_in_q : '0;
				left_q    <= load_ok ? AMOUNT_W'(amt_q) : '0;
			end else begin
				granted_q <= found_q;
				chosen_q  <= found_q ? INDEX_W'(best_idx_q) : '0;
				left_q    <= found_q ? AMOUNT_W'(left_w) : '0;
			end
		end
	end

	// table: one read port for the scan, one write port for the update
	always_ff @(posedge clk) begin
		rd_data_s1 <= mem[pos_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (kind_q == REQ_LOAD) begin
				if (load_ok) begin
					mem[load_addr] <= amt_q;
				end
			end else if (found_q) begin
				mem[best_idx_q] <= left_w;
			end
		end
	end

	`FBA_ASSERT_SAME(a_issue_range, cmd.issue, CNT_W'(pos_q) < count_q,
		"scan address outside searched blocks")
	`FBA_ASSERT_SAME(a_found_range, found_q, CNT_W'(best_idx_q) < count_q,
		"chosen block outside searched blocks")
	`FBA_ASSERT_ALWAYS(a_step_range, step_q <= count_q, "scan ran past block count")

endmodule
